/* rtl/fsne_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT short name encoder package
// Shared beat types, byte codes and sizes for the 8.3 name encoder.
// ----------------------------------------------------------------------------
package fsne_pkg;

    // Byte codes that the encoder recognizes.
    localparam logic [7:0] SPACE_BYTE     = 8'h20;
    localparam logic [7:0] DOT_BYTE       = 8'h2E;
    localparam logic [7:0] SLASH_BYTE     = 8'h2F;
    localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
    localparam logic [7:0] LOWER_A_BYTE   = 8'h61;
    localparam logic [7:0] LOWER_Z_BYTE   = 8'h7A;
    localparam logic [7:0] CASE_OFFSET    = 8'h20;

    // Name layout: eight base bytes followed by three extension bytes.
    localparam int          NAME_BYTES = 11;
    localparam logic [3:0]  BASE_MAX   = 4'd8;
    localparam logic [2:0]  EXT_MAX    = 3'd3;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Status codes of a result beat.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // Input beat: one character of the path component.
    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic       is_empty;
    } in_beat_t;

    // Output beat: the finished 8.3 name.
    typedef struct packed {
        logic        status;
        logic [63:0] base_bytes;
        logic [23:0] extension_bytes;
    } out_beat_t;

    // Classified character as it waits in the queue.
    typedef struct packed {
        logic [7:0] upper_char;
        logic       is_dot;
        logic       base_bad;
        logic       last;
        logic       is_empty;
    } class_entry_t;

endpackage

/* rtl/fsne_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT short name encoder front part
// Accepts input beats and classifies each character for the back part.
// ----------------------------------------------------------------------------
module fsne_front
(
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fsne_pkg::in_beat_t    in_data,
    input  logic                  queue_full,
    output logic                  push,
    output fsne_pkg::class_entry_t push_entry
);

    logic [7:0] upper_char;

    // Take a beat whenever the queue has room.
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // Upper-case a..z only; every other byte passes unchanged.
    always_comb
    begin
        if (in_data.character >= fsne_pkg::LOWER_A_BYTE &&
            in_data.character <= fsne_pkg::LOWER_Z_BYTE)
        begin
            upper_char = in_data.character - fsne_pkg::CASE_OFFSET;
        end
        else
        begin
            upper_char = in_data.character;
        end
    end

    // Classify the character for the back part.
    always_comb
    begin
        push_entry.upper_char = upper_char;
        push_entry.is_dot     = (in_data.character == fsne_pkg::DOT_BYTE);
        push_entry.base_bad   = (upper_char == fsne_pkg::SLASH_BYTE) ||
                                (upper_char == fsne_pkg::BACKSLASH_BYTE) ||
                                (upper_char < fsne_pkg::SPACE_BYTE);
        push_entry.last       = in_data.last;
        push_entry.is_empty   = in_data.is_empty;
    end

endmodule

/* rtl/fsne_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT short name encoder queue
// Short first-in first-out queue of classified characters.
// ----------------------------------------------------------------------------
module fsne_queue
#(
    parameter int DEPTH = fsne_pkg::QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  fsne_pkg::class_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output fsne_pkg::class_entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fsne_pkg::class_entry_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/fsne_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT short name encoder back part
// Builds the 11-byte name from classified characters and registers results.
// ----------------------------------------------------------------------------
module fsne_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  fsne_pkg::class_entry_t head_entry,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fsne_pkg::out_beat_t    out_data
);

    logic [7:0] name_reg  [fsne_pkg::NAME_BYTES];
    logic [7:0] name_next [fsne_pkg::NAME_BYTES];
    logic [3:0] base_count_reg, base_count_next;
    logic [2:0] ext_count_reg, ext_count_next;
    logic       dot_seen_reg, dot_seen_next;
    logic       invalid_reg, invalid_next;
    logic       out_valid_reg, out_valid_next;
    fsne_pkg::out_beat_t out_data_reg;
    logic       write_en;
    logic [3:0] write_idx;
    logic       bad;
    logic       finish;
    logic [63:0] base_word;
    logic [23:0] ext_word;

    // A final character waits only while the result register is still full.
    assign pop    = head_valid && (!head_entry.last || !out_valid_reg || out_ready);
    assign finish = pop && head_entry.last;

    // Absorb one character: counters, flags and the store write address.
    always_comb
    begin
        base_count_next = base_count_reg;
        ext_count_next  = ext_count_reg;
        dot_seen_next   = dot_seen_reg;
        invalid_next    = invalid_reg;
        write_en        = 1'b0;
        write_idx       = '0;
        if (pop && !head_entry.is_empty)
        begin
            if (head_entry.is_dot)
            begin
                if (dot_seen_reg)
                begin
                    invalid_next = 1'b1;
                end
                dot_seen_next = 1'b1;
            end
            else if (!dot_seen_reg)
            begin
                if (head_entry.base_bad)
                begin
                    invalid_next = 1'b1;
                end
                if (base_count_reg < fsne_pkg::BASE_MAX)
                begin
                    write_en  = 1'b1;
                    write_idx = base_count_reg;
                end
                else
                begin
                    invalid_next = 1'b1;
                end
                if (base_count_reg <= fsne_pkg::BASE_MAX)
                begin
                    base_count_next = base_count_reg + 4'd1;
                end
            end
            else
            begin
                if (ext_count_reg < fsne_pkg::EXT_MAX)
                begin
                    write_en  = 1'b1;
                    write_idx = fsne_pkg::BASE_MAX + {1'b0, ext_count_reg};
                end
                else
                begin
                    invalid_next = 1'b1;
                end
                if (ext_count_reg <= fsne_pkg::EXT_MAX)
                begin
                    ext_count_next = ext_count_reg + 3'd1;
                end
            end
        end
    end

    // Store with this character written in.
    always_comb
    begin
        for (int i = 0; i < fsne_pkg::NAME_BYTES; i++)
        begin
            name_next[i] = (write_en && write_idx == 4'(i)) ? head_entry.upper_char
                                                            : name_reg[i];
        end
    end

    // Verdict and packed name for a finishing component.
    assign bad = invalid_next || (base_count_next == 4'd0) ||
                 (base_count_next > fsne_pkg::BASE_MAX) ||
                 (ext_count_next > fsne_pkg::EXT_MAX);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            base_word[8*i +: 8] = bad ? fsne_pkg::SPACE_BYTE : name_next[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            ext_word[8*i +: 8] = bad ? fsne_pkg::SPACE_BYTE : name_next[8 + i];
        end
    end

    // Component state; cleared back to spaces after each finished name.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fsne_pkg::NAME_BYTES; i++)
            begin
                name_reg[i] <= fsne_pkg::SPACE_BYTE;
            end
            base_count_reg <= '0;
            ext_count_reg  <= '0;
            dot_seen_reg   <= 1'b0;
            invalid_reg    <= 1'b0;
        end
        else if (finish)
        begin
            for (int i = 0; i < fsne_pkg::NAME_BYTES; i++)
            begin
                name_reg[i] <= fsne_pkg::SPACE_BYTE;
            end
            base_count_reg <= '0;
            ext_count_reg  <= '0;
            dot_seen_reg   <= 1'b0;
            invalid_reg    <= 1'b0;
        end
        else
        begin
            name_reg       <= name_next;
            base_count_reg <= base_count_next;
            ext_count_reg  <= ext_count_next;
            dot_seen_reg   <= dot_seen_next;
            invalid_reg    <= invalid_next;
        end
    end

    // Result register.
    always_comb
    begin
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg.status          <= bad ? fsne_pkg::STATUS_INVALID
                                                : fsne_pkg::STATUS_OK;
            out_data_reg.base_bytes      <= base_word;
            out_data_reg.extension_bytes <= ext_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/fat_short_name_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT short name encoder
// Turns a path component, one character per beat, into an 8.3 directory name.
// ----------------------------------------------------------------------------
// The encoder takes one character beat per clock cycle while the queue has
// room and sustains that rate across component boundaries. A front part
// upper-cases and classifies each character, a short queue holds them, and a
// back part writes them into the eleven-byte name store. The result beat is
// registered once the back part takes the beat marked last, which it holds
// only while the previous result sits untaken in the output register. An
// invalid component is reported with status 1 and an all-space name.
// ----------------------------------------------------------------------------
module fat_short_name_encoder
#(
    parameter int QUEUE_DEPTH = fsne_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fsne_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fsne_pkg::out_beat_t out_data
);

    logic                   queue_full;
    logic                   push;
    fsne_pkg::class_entry_t push_entry;
    logic                   pop;
    logic                   head_valid;
    fsne_pkg::class_entry_t head_entry;

    // Accept and classify.
    fsne_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decoupling queue.
    fsne_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Build the name and deliver results.
    fsne_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

/* rtl/fsne_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT short name encoder checker
// Port-level assertions on the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fsne_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input fsne_pkg::in_beat_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input fsne_pkg::out_beat_t out_data
);

    logic       base_has_dot;
    logic [7:0] first_byte;

    assign first_byte = out_data.base_bytes[7:0];

    // A dot never lands in the base bytes of a name.
    always_comb
    begin
        base_has_dot = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (out_data.base_bytes[8*i +: 8] == fsne_pkg::DOT_BYTE)
            begin
                base_has_dot = 1'b1;
            end
        end
    end

    // A waiting input beat stays offered and unchanged until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat changed before it was taken");

    // A waiting result beat stays offered until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat withdrawn before it was taken");

    // An invalid component reports an all-space name.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == fsne_pkg::STATUS_INVALID |->
        out_data.base_bytes == {8{fsne_pkg::SPACE_BYTE}} &&
        out_data.extension_bytes == {3{fsne_pkg::SPACE_BYTE}})
        else $error("invalid result carries name bytes");

    // A valid name holds no dot in its base.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == fsne_pkg::STATUS_OK |-> !base_has_dot)
        else $error("dot stored in base of a valid name");

    // A valid name starts with a legal, upper-cased base character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == fsne_pkg::STATUS_OK |->
        first_byte >= fsne_pkg::SPACE_BYTE &&
        first_byte != fsne_pkg::SLASH_BYTE &&
        first_byte != fsne_pkg::BACKSLASH_BYTE &&
        (first_byte < fsne_pkg::LOWER_A_BYTE || first_byte > fsne_pkg::LOWER_Z_BYTE))
        else $error("valid name starts with an illegal base character");

endmodule

bind fat_short_name_encoder fsne_checker u_fsne_checker (.*);

/* tb/sv/tb_fat_short_name_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT short name encoder testbench
// Streams path components through the encoder one character beat at a time.
// The bench predicts each 8.3 name and its status, and checks every result
// beat in order. Both channels idle at random in the first two phases, and
// the last phase runs at full rate.
// ----------------------------------------------------------------------------
module tb_fat_short_name_encoder;

    localparam int STALL_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 10;
    localparam int BEATS_PER_PHASE = 600;
    localparam int REPORT_LIMIT    = 10;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    fsne_pkg::in_beat_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    fsne_pkg::out_beat_t out_data;

    fsne_pkg::in_beat_t  pending_beats[$];
    fsne_pkg::out_beat_t expected_names[$];
    int        beats_queued  = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        fail_count    = 0;
    int        idle_cycles   = 0;

    // Predicted state of the encoder for the component in progress.
    logic [7:0] name_bytes [fsne_pkg::NAME_BYTES];
    logic [3:0] base_len;
    logic [2:0] ext_len;
    logic       dot_flag;
    logic       bad_flag;

    fat_short_name_encoder u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Return the predicted state to an empty, all-space name.
    task automatic clear_name();
        for (int i = 0; i < fsne_pkg::NAME_BYTES; i++)
        begin
            name_bytes[i] = fsne_pkg::SPACE_BYTE;
        end
        base_len = '0;
        ext_len  = '0;
        dot_flag = 1'b0;
        bad_flag = 1'b0;
    endtask

    // Fold one accepted character beat into the name; on the last beat,
    // queue the finished name and start over.
    task automatic predict_name(input fsne_pkg::in_beat_t beat);
        logic [7:0]          up;
        logic                bad;
        fsne_pkg::out_beat_t name;
        up = (beat.character >= fsne_pkg::LOWER_A_BYTE &&
              beat.character <= fsne_pkg::LOWER_Z_BYTE) ?
             beat.character - fsne_pkg::CASE_OFFSET : beat.character;
        if (!beat.is_empty)
        begin
            if (beat.character == fsne_pkg::DOT_BYTE)
            begin
                if (dot_flag)
                    bad_flag = 1'b1;
                dot_flag = 1'b1;
            end
            else if (!dot_flag)
            begin
                if (up == fsne_pkg::SLASH_BYTE || up == fsne_pkg::BACKSLASH_BYTE ||
                    up < fsne_pkg::SPACE_BYTE)
                    bad_flag = 1'b1;
                if (base_len < fsne_pkg::BASE_MAX)
                    name_bytes[base_len] = up;
                else
                    bad_flag = 1'b1;
                if (base_len <= fsne_pkg::BASE_MAX)
                    base_len = base_len + 4'd1;
            end
            else
            begin
                if (ext_len < fsne_pkg::EXT_MAX)
                    name_bytes[int'(fsne_pkg::BASE_MAX) + int'(ext_len)] = up;
                else
                    bad_flag = 1'b1;
                if (ext_len <= fsne_pkg::EXT_MAX)
                    ext_len = ext_len + 3'd1;
            end
        end
        if (beat.last)
        begin
            bad = bad_flag || base_len == '0 || base_len > fsne_pkg::BASE_MAX ||
                  ext_len > fsne_pkg::EXT_MAX;
            name.status = bad ? fsne_pkg::STATUS_INVALID : fsne_pkg::STATUS_OK;
            for (int i = 0; i < int'(fsne_pkg::BASE_MAX); i++)
            begin
                name.base_bytes[8*i +: 8] = bad ? fsne_pkg::SPACE_BYTE : name_bytes[i];
            end
            for (int i = 0; i < int'(fsne_pkg::EXT_MAX); i++)
            begin
                name.extension_bytes[8*i +: 8] =
                    bad ? fsne_pkg::SPACE_BYTE : name_bytes[int'(fsne_pkg::BASE_MAX) + i];
            end
            expected_names.push_back(name);
            clear_name();
        end
    endtask

    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, what);
    endtask

    // Empty beats without last are ignored by the encoder and not counted.
    task automatic queue_beat(input logic [7:0] ch, input logic last, input logic empty);
        fsne_pkg::in_beat_t beat;
        beat.character = ch;
        beat.last      = last;
        beat.is_empty  = empty;
        pending_beats.push_back(beat);
        if (!(empty && !last))
            beats_queued++;
    endtask

    // A byte that is legal in the base, biased toward lower-case letters.
    function automatic logic [7:0] base_char();
        logic [7:0] c;
        if ($urandom_range(2) == 0)
            return 8'($urandom_range(fsne_pkg::LOWER_A_BYTE, fsne_pkg::LOWER_Z_BYTE));
        c = 8'($urandom_range(fsne_pkg::SPACE_BYTE, 8'hFF));
        while (c == fsne_pkg::DOT_BYTE || c == fsne_pkg::SLASH_BYTE ||
               c == fsne_pkg::BACKSLASH_BYTE)
        begin
            c = 8'($urandom_range(fsne_pkg::SPACE_BYTE, 8'hFF));
        end
        return c;
    endfunction

    // Emit a component as beats, with stray empty beats mixed in and
    // sometimes closed by an empty beat carrying last.
    task automatic queue_component(input logic [7:0] chars[$], input logic end_empty);
        for (int i = 0; i < chars.size(); i++)
        begin
            if ($urandom_range(19) == 0)
                queue_beat(8'($urandom), 1'b0, 1'b1);
            queue_beat(chars[i], (i == chars.size() - 1) && !end_empty, 1'b0);
        end
        if (chars.size() == 0 || end_empty)
            queue_beat(8'($urandom), 1'b1, 1'b1);
    endtask

    // Mostly well-formed names, some names with one flaw, and some raw noise.
    task automatic queue_random_component();
        logic [7:0] chars[$];
        logic [7:0] c;
        logic       with_dot;
        int         mode;
        int         flaw;
        int         base_n;
        int         ext_n;
        int         pos;
        mode     = $urandom_range(99);
        flaw     = (mode >= 60 && mode < 85) ? $urandom_range(4) : -1;
        base_n   = $urandom_range(1, 8);
        ext_n    = $urandom_range(0, 3);
        with_dot = (ext_n > 0) || ($urandom_range(1) == 1);
        case (flaw)
            0: base_n = $urandom_range(9, 11);
            1:
            begin
                ext_n    = $urandom_range(4, 6);
                with_dot = 1'b1;
            end
            2: base_n = 0;
            default: ;
        endcase
        for (int i = 0; i < base_n; i++)
        begin
            chars.push_back(base_char());
        end
        if (with_dot)
            chars.push_back(fsne_pkg::DOT_BYTE);
        for (int i = 0; i < ext_n; i++)
        begin
            c = 8'($urandom);
            chars.push_back(c == fsne_pkg::DOT_BYTE ? 8'($urandom_range(0, 8'h2D)) : c);
        end
        if (flaw == 3)
        begin
            pos = $urandom_range(base_n - 1);
            case ($urandom_range(2))
                0: chars[pos] = fsne_pkg::SLASH_BYTE;
                1: chars[pos] = fsne_pkg::BACKSLASH_BYTE;
                default: chars[pos] = 8'($urandom_range(0, fsne_pkg::SPACE_BYTE - 8'd1));
            endcase
        end
        else if (flaw == 4)
        begin
            chars.insert($urandom_range(chars.size()), fsne_pkg::DOT_BYTE);
        end
        if (mode >= 85)
        begin
            chars.delete();
            repeat ($urandom_range(0, 12))
            begin
                chars.push_back(($urandom_range(7) == 0) ? fsne_pkg::DOT_BYTE : 8'($urandom));
            end
        end
        queue_component(chars, $urandom_range(4) == 0);
    endtask

    // Sender: offer the next pending beat once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_beats.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall the result channel at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Predict on every accepted character beat and check every result beat.
    always @(posedge clk)
    begin
        fsne_pkg::out_beat_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_name(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_names.size() == 0)
                begin
                    report_failure($sformatf("result beat with no name expected: %h",
                                             out_data));
                end
                else
                begin
                    want = expected_names.pop_front();
                    if (out_data.status !== want.status ||
                        out_data.base_bytes !== want.base_bytes ||
                        out_data.extension_bytes !== want.extension_bytes)
                    begin
                        report_failure($sformatf(
                            "expected status %0d base %h ext %h, got status %0d base %h ext %h",
                            want.status, want.base_bytes, want.extension_bytes,
                            out_data.status, out_data.base_bytes, out_data.extension_bytes));
                    end
                end
            end
        end
    end

    // Watchdog: too long without any beat accepted on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Reset, then three phases of stimulus with different idling.
    initial
    begin
        int target;
        clear_name();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 3; phase++)
        begin
            @(negedge clk);
            case (phase)
                0:
                begin
                    send_idle_pct = 17;
                    recv_idle_pct = 74;
                end
                1:
                begin
                    send_idle_pct = 74;
                    recv_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0)
            begin
                // Empty component.
                queue_beat(8'h00, 1'b1, 1'b1);
                // Lower-case edges, an ignored empty beat, a trailing dot,
                // closed by an empty beat.
                queue_beat(fsne_pkg::LOWER_A_BYTE, 1'b0, 1'b0);
                queue_beat(fsne_pkg::LOWER_Z_BYTE, 1'b0, 1'b0);
                queue_beat(8'hFF, 1'b0, 1'b1);
                queue_beat(fsne_pkg::DOT_BYTE, 1'b0, 1'b0);
                queue_beat(8'hFF, 1'b1, 1'b1);
                // Bytes just outside the lower-case range, the top byte, and
                // a zero byte in the extension, which is not checked.
                queue_beat(8'h60, 1'b0, 1'b0);
                queue_beat(8'h7B, 1'b0, 1'b0);
                queue_beat(8'hFF, 1'b0, 1'b0);
                queue_beat(fsne_pkg::DOT_BYTE, 1'b0, 1'b0);
                queue_beat(8'h00, 1'b1, 1'b0);
                // Empty base before the dot.
                queue_beat(fsne_pkg::DOT_BYTE, 1'b0, 1'b0);
                queue_beat(8'h78, 1'b1, 1'b0);
                // Slash, control byte and backslash in the base.
                queue_beat(8'h41, 1'b0, 1'b0);
                queue_beat(fsne_pkg::SLASH_BYTE, 1'b1, 1'b0);
                queue_beat(8'h1F, 1'b1, 1'b0);
                queue_beat(fsne_pkg::BACKSLASH_BYTE, 1'b1, 1'b0);
                // Two dots.
                queue_beat(8'h41, 1'b0, 1'b0);
                queue_beat(fsne_pkg::DOT_BYTE, 1'b0, 1'b0);
                queue_beat(fsne_pkg::DOT_BYTE, 1'b1, 1'b0);
                // Extension one character too long.
                queue_beat(8'h41, 1'b0, 1'b0);
                queue_beat(fsne_pkg::DOT_BYTE, 1'b0, 1'b0);
                queue_beat(8'h62, 1'b0, 1'b0);
                queue_beat(8'h63, 1'b0, 1'b0);
                queue_beat(8'h64, 1'b0, 1'b0);
                queue_beat(8'h65, 1'b1, 1'b0);
            end
            target = beats_queued + BEATS_PER_PHASE;
            while (beats_queued < target)
            begin
                queue_random_component();
            end
            while (pending_beats.size() != 0 || in_valid || expected_names.size() != 0)
            begin
                @(negedge clk);
            end
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_names.size() != 0)
            report_failure($sformatf("%0d expected names never arrived",
                                     expected_names.size()));
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
